FILE: hdl/channel_noise_threshold_calibrator_assert.svh
// assertion macros shared by the calibrator modules
`ifndef CHANNEL_NOISE_THRESHOLD_CALIBRATOR_ASSERT_SVH
`define CHANNEL_NOISE_THRESHOLD_CALIBRATOR_ASSERT_SVH

// same-cycle implication
`define CNTC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("calibrator assertion failed");

// next-cycle implication
`define CNTC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("calibrator assertion failed");

`endif

FILE: hdl/cntc_pkg.sv
// shared constants of the noise threshold calibrator
package cntc_pkg;

	localparam int WAVE_SAMPLES_DEF          = 512;
	localparam int NUM_FRONTENDS_DEF         = 32;
	localparam int CHANNELS_PER_FRONTEND_DEF = 64;
	localparam int SAMPLE_BITS_DEF           = 12;

	localparam int QUEUE_DEPTH    = 4;
	localparam int SAMPLE_FIELD_W = 12;
	localparam int SIGMA_W        = 6;
	localparam int DFLT_W         = 16;
	localparam int TSUM_W         = 32;
	localparam int TCNT_W         = 16;
	localparam int OUT_W          = 16;

	localparam logic [SIGMA_W-1:0] SIGMA_RESET = 6'd15;
	localparam logic [DFLT_W-1:0]  DFLT_RESET  = 16'd590;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam logic REG_SIGMA   = 1'b0;
	localparam logic REG_DEFAULT = 1'b1;

endpackage

FILE: hdl/cntc_front.sv
// front part: waveform accumulation and job classification
module cntc_front #(
	parameter int WAVE_SAMPLES          = cntc_pkg::WAVE_SAMPLES_DEF,
	parameter int NUM_FRONTENDS         = cntc_pkg::NUM_FRONTENDS_DEF,
	parameter int CHANNELS_PER_FRONTEND = cntc_pkg::CHANNELS_PER_FRONTEND_DEF,
	parameter int SAMPLE_BITS           = cntc_pkg::SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic cmd,
	input  logic [7:0] frontend_id,
	input  logic [6:0] channel_number,
	input  logic [cntc_pkg::SAMPLE_FIELD_W-1:0] sample_value,
	input  logic last_sample,
	input  logic full,
	input  logic clearing,
	output logic push,
	output logic [1+((NUM_FRONTENDS*CHANNELS_PER_FRONTEND > 1) ?
		$clog2(NUM_FRONTENDS*CHANNELS_PER_FRONTEND) : 1) +
		3*SAMPLE_BITS + 3*$clog2(WAVE_SAMPLES+1)-1:0] job
);
	localparam int LEN_W = $clog2(WAVE_SAMPLES+1);
	localparam int SUM_W = SAMPLE_BITS + LEN_W;
	localparam int SQ_W  = 2*SAMPLE_BITS + LEN_W;
	localparam int DEPTH = NUM_FRONTENDS * CHANNELS_PER_FRONTEND;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [SAMPLE_BITS-1:0] samp;
	logic [2*SAMPLE_BITS-1:0] samp_sq;
	logic [SUM_W-1:0] sum_q, sum_nx;
	logic [SQ_W-1:0] sq_q, sq_nx;
	logic [LEN_W-1:0] len_q, len_nx;
	logic acc_en, addr_ok, accept;
	logic [15:0] idx_full;

	if (SAMPLE_BITS <= cntc_pkg::SAMPLE_FIELD_W) begin : g_trunc
		assign samp = sample_value[SAMPLE_BITS-1:0];
	end else begin : g_ext
		assign samp = {{(SAMPLE_BITS-cntc_pkg::SAMPLE_FIELD_W){1'b0}}, sample_value};
	end

	assign samp_sq = samp * samp;
	assign acc_en  = len_q < LEN_W'(WAVE_SAMPLES);
	assign sum_nx  = acc_en ? sum_q + SUM_W'(samp) : sum_q;
	assign sq_nx   = acc_en ? sq_q + SQ_W'(samp_sq) : sq_q;
	assign len_nx  = acc_en ? len_q + LEN_W'(1) : len_q;

	assign addr_ok  = ({1'b0, frontend_id} < 9'(NUM_FRONTENDS)) &&
		({1'b0, channel_number} < 8'(CHANNELS_PER_FRONTEND));
	assign idx_full = 16'(frontend_id) * 16'(CHANNELS_PER_FRONTEND) + 16'(channel_number);

	assign in_ready = !clearing && !full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && addr_ok && (cmd == cntc_pkg::CMD_READ || last_sample);
	assign job      = {cmd, idx_full[IDX_W-1:0], sum_nx, sq_nx, len_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sq_q  <= '0;
			len_q <= '0;
		end else if (accept && cmd == cntc_pkg::CMD_SAMPLE) begin
			if (last_sample) begin
				sum_q <= '0;
				sq_q  <= '0;
				len_q <= '0;
			end else begin
				sum_q <= sum_nx;
				sq_q  <= sq_nx;
				len_q <= len_nx;
			end
		end
	end

endmodule

FILE: hdl/cntc_fifo.sv
// job queue between front and back parts
`include "channel_noise_threshold_calibrator_assert.svh"

module cntc_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = cntc_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [W-1:0] wdata,
	input  logic pop,
	output logic [W-1:0] rdata,
	output logic full,
	output logic empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = cnt_q == CNT_W'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH-1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH-1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	`CNTC_ASSERT_NOW(a_no_overflow, push, !full)

endmodule

FILE: hdl/cntc_back.sv
// back part: threshold arithmetic, channel tables and read results
`include "channel_noise_threshold_calibrator_assert.svh"

module cntc_back #(
	parameter int WAVE_SAMPLES          = cntc_pkg::WAVE_SAMPLES_DEF,
	parameter int NUM_FRONTENDS         = cntc_pkg::NUM_FRONTENDS_DEF,
	parameter int CHANNELS_PER_FRONTEND = cntc_pkg::CHANNELS_PER_FRONTEND_DEF,
	parameter int SAMPLE_BITS           = cntc_pkg::SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [cntc_pkg::SIGMA_W-1:0] sigma_multiple,
	input  logic [cntc_pkg::DFLT_W-1:0] default_threshold,
	input  logic empty,
	input  logic [1+((NUM_FRONTENDS*CHANNELS_PER_FRONTEND > 1) ?
		$clog2(NUM_FRONTENDS*CHANNELS_PER_FRONTEND) : 1) +
		3*SAMPLE_BITS + 3*$clog2(WAVE_SAMPLES+1)-1:0] job,
	output logic pop,
	output logic clearing,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [cntc_pkg::OUT_W-1:0] avg_threshold,
	output logic [cntc_pkg::OUT_W-1:0] event_count
);
	localparam int LEN_W  = $clog2(WAVE_SAMPLES+1);
	localparam int SUM_W  = SAMPLE_BITS + LEN_W;
	localparam int SQ_W   = 2*SAMPLE_BITS + LEN_W;
	localparam int DEPTH  = NUM_FRONTENDS * CHANNELS_PER_FRONTEND;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int JOB_W  = 1 + IDX_W + SUM_W + SQ_W + LEN_W;
	localparam int D_W    = LEN_W + SQ_W;
	localparam int DVD_W  = (D_W + 16 > cntc_pkg::TSUM_W) ? D_W + 16 : cntc_pkg::TSUM_W;
	localparam int DVS_W  = (2*LEN_W > cntc_pkg::TCNT_W) ? 2*LEN_W : cntc_pkg::TCNT_W;
	localparam int VAR_W  = 2*SAMPLE_BITS + 16;
	localparam int RT_W   = VAR_W / 2;
	localparam int MEAN_W = SAMPLE_BITS + 8;
	localparam int KP_W   = RT_W + cntc_pkg::SIGMA_W;
	localparam int T_W    = RT_W + 8;
	localparam int TH_W   = T_W - 8;
	localparam int TAB_W  = cntc_pkg::TSUM_W + cntc_pkg::TCNT_W;
	localparam int STEP_W = $clog2(DVD_W+1);

	typedef enum logic [13:0] {
		ST_CLEAR    = 14'h0001,
		ST_IDLE     = 14'h0002,
		ST_MUL_NQ   = 14'h0004,
		ST_MUL_SS   = 14'h0008,
		ST_MUL_NN   = 14'h0010,
		ST_DIV_VAR  = 14'h0020,
		ST_SQRT     = 14'h0040,
		ST_DIV_MEAN = 14'h0080,
		ST_THR_MUL  = 14'h0100,
		ST_THR_ADD  = 14'h0200,
		ST_TAB_RD   = 14'h0400,
		ST_TAB_USE  = 14'h0800,
		ST_RD_DIV   = 14'h1000,
		ST_OUT      = 14'h2000
	} state_t;

	state_t st_q, st_nx;

	logic j_kind;
	logic [IDX_W-1:0] j_idx;
	logic [SUM_W-1:0] j_s;
	logic [SQ_W-1:0] j_q;
	logic [LEN_W-1:0] j_n;

	logic kind_q;
	logic [IDX_W-1:0] idx_q;
	logic [SUM_W-1:0] s_q;
	logic [LEN_W-1:0] n_q;

	logic [STEP_W-1:0] cnt_q;
	logic [IDX_W-1:0] clr_cnt_q;
	logic last_step, stepping;

	// shift-add multiplier
	logic [D_W-1:0] acc_q, acc_nx, mula_q, d_q;
	logic [SUM_W-1:0] mulb_q;

	// restoring divider
	logic [DVD_W-1:0] dvd_q, dvd_nx;
	logic [DVS_W-1:0] dvs_q, rem_q;
	logic [DVS_W:0] dtry, drem_nx;
	logic dge;

	// digit-by-digit square root
	logic [VAR_W-1:0] sqv_q;
	logic [RT_W-1:0] sres_q, sres_nx;
	logic [RT_W:0] srem_q;
	logic [RT_W+2:0] r2, trial, srem_nx;
	logic sge;

	logic [KP_W-1:0] kprod_q;
	logic [T_W-1:0] tsum;
	logic [TH_W-1:0] th_q;

	logic [TAB_W-1:0] tab [DEPTH];
	logic [TAB_W-1:0] tab_rd_q, mem_wd;
	logic [IDX_W-1:0] mem_wa;
	logic mem_we;
	logic [cntc_pkg::TSUM_W-1:0] t_sum, s_sel;
	logic [cntc_pkg::TCNT_W-1:0] t_cnt, c_sel, evc_hold_q;
	logic [cntc_pkg::TSUM_W:0] sum_add;

	logic ovalid_q, out_load;
	logic [cntc_pkg::OUT_W-1:0] avg_q, evc_q;

	assign j_kind = job[JOB_W-1];
	assign j_idx  = job[JOB_W-2 -: IDX_W];
	assign j_s    = job[LEN_W+SQ_W +: SUM_W];
	assign j_q    = job[LEN_W +: SQ_W];
	assign j_n    = job[LEN_W-1:0];

	assign pop      = (st_q == ST_IDLE) && !empty;
	assign clearing = st_q == ST_CLEAR;

	assign acc_nx = mulb_q[0] ? acc_q + mula_q : acc_q;

	assign dtry    = {rem_q, dvd_q[DVD_W-1]};
	assign dge     = dtry >= {1'b0, dvs_q};
	assign drem_nx = dge ? dtry - {1'b0, dvs_q} : dtry;
	assign dvd_nx  = {dvd_q[DVD_W-2:0], dge};

	assign r2      = {srem_q, sqv_q[VAR_W-1 -: 2]};
	assign trial   = {1'b0, sres_q, 2'b01};
	assign sge     = r2 >= trial;
	assign srem_nx = sge ? r2 - trial : r2;
	assign sres_nx = {sres_q[RT_W-2:0], sge};

	// mean_q8 + k*sigma_q8, rounded half up
	assign tsum = T_W'(dvd_q[MEAN_W-1:0]) + T_W'(kprod_q) + T_W'(128);

	assign t_sum   = tab_rd_q[cntc_pkg::TSUM_W-1:0];
	assign t_cnt   = tab_rd_q[TAB_W-1 -: cntc_pkg::TCNT_W];
	assign sum_add = {1'b0, t_sum} + (cntc_pkg::TSUM_W+1)'(th_q);
	assign s_sel   = (t_sum == '0) ? cntc_pkg::TSUM_W'(default_threshold) : t_sum;
	assign c_sel   = (t_cnt == '0) ? cntc_pkg::TCNT_W'(1) : t_cnt;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = '0;
		if (st_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_cnt_q;
		end else if (st_q == ST_TAB_USE && kind_q == cntc_pkg::CMD_SAMPLE &&
			t_cnt != '1) begin
			mem_we = 1'b1;
			mem_wd = {t_cnt + cntc_pkg::TCNT_W'(1),
				sum_add[cntc_pkg::TSUM_W] ? {cntc_pkg::TSUM_W{1'b1}} :
				sum_add[cntc_pkg::TSUM_W-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tab[mem_wa] <= mem_wd;
		end
		tab_rd_q <= tab[idx_q];
	end

	always_comb begin
		stepping  = 1'b1;
		last_step = 1'b0;
		case (st_q) inside
			ST_MUL_NQ, ST_MUL_SS, ST_MUL_NN: last_step = cnt_q == STEP_W'(SUM_W-1);
			ST_DIV_VAR, ST_DIV_MEAN, ST_RD_DIV: last_step = cnt_q == STEP_W'(DVD_W-1);
			ST_SQRT: last_step = cnt_q == STEP_W'(RT_W-1);
			default: stepping = 1'b0;
		endcase
	end

	assign out_load = (st_q == ST_OUT) && (!ovalid_q || m_tready);

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			ST_CLEAR: begin
				if (clr_cnt_q == IDX_W'(DEPTH-1)) st_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (!empty) begin
					if (j_kind == cntc_pkg::CMD_READ || j_n == '0) st_nx = ST_TAB_RD;
					else if (j_n == LEN_W'(1)) st_nx = ST_DIV_MEAN;
					else st_nx = ST_MUL_NQ;
				end
			end
			ST_MUL_NQ:   if (last_step) st_nx = ST_MUL_SS;
			ST_MUL_SS:   if (last_step) st_nx = ST_MUL_NN;
			ST_MUL_NN:   if (last_step) st_nx = ST_DIV_VAR;
			ST_DIV_VAR:  if (last_step) st_nx = ST_SQRT;
			ST_SQRT:     if (last_step) st_nx = ST_DIV_MEAN;
			ST_DIV_MEAN: if (last_step) st_nx = ST_THR_MUL;
			ST_THR_MUL:  st_nx = ST_THR_ADD;
			ST_THR_ADD:  st_nx = ST_TAB_RD;
			ST_TAB_RD:   st_nx = ST_TAB_USE;
			ST_TAB_USE:  st_nx = (kind_q == cntc_pkg::CMD_READ) ? ST_RD_DIV : ST_IDLE;
			ST_RD_DIV:   if (last_step) st_nx = ST_OUT;
			ST_OUT:      if (out_load) st_nx = ST_IDLE;
			default:     st_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLEAR;
			cnt_q     <= '0;
			clr_cnt_q <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (stepping && !last_step) cnt_q <= cnt_q + STEP_W'(1);
			else cnt_q <= '0;
			if (st_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + IDX_W'(1);
			if (out_load) ovalid_q <= 1'b1;
			else if (m_tready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q) inside
			ST_IDLE: begin
				kind_q <= j_kind;
				idx_q  <= j_idx;
				s_q    <= j_s;
				n_q    <= j_n;
				acc_q  <= '0;
				mula_q <= D_W'(j_q);
				mulb_q <= SUM_W'(j_n);
				sres_q <= '0;
				th_q   <= '0;
				dvd_q  <= DVD_W'({j_s, 8'h00});
				dvs_q  <= DVS_W'(j_n);
				rem_q  <= '0;
			end
			ST_MUL_NQ, ST_MUL_SS, ST_MUL_NN: begin
				acc_q  <= acc_nx;
				mula_q <= mula_q << 1;
				mulb_q <= mulb_q >> 1;
				if (last_step) begin
					acc_q <= '0;
					if (st_q == ST_MUL_NQ) begin
						d_q    <= acc_nx;
						mula_q <= D_W'(s_q);
						mulb_q <= s_q;
					end else if (st_q == ST_MUL_SS) begin
						d_q    <= d_q - acc_nx;
						mula_q <= D_W'(n_q);
						mulb_q <= SUM_W'(n_q - LEN_W'(1));
					end else begin
						// (n*Q - S*S) * 2^16 over n*(n-1)
						dvd_q <= DVD_W'({d_q, 16'h0000});
						dvs_q <= acc_nx[DVS_W-1:0];
						rem_q <= '0;
					end
				end
			end
			ST_DIV_VAR, ST_DIV_MEAN, ST_RD_DIV: begin
				dvd_q <= dvd_nx;
				rem_q <= drem_nx[DVS_W-1:0];
				if (last_step && st_q == ST_DIV_VAR) begin
					sqv_q  <= dvd_nx[VAR_W-1:0];
					sres_q <= '0;
					srem_q <= '0;
				end
			end
			ST_SQRT: begin
				sqv_q  <= sqv_q << 2;
				sres_q <= sres_nx;
				srem_q <= srem_nx[RT_W:0];
				if (last_step) begin
					dvd_q <= DVD_W'({s_q, 8'h00});
					dvs_q <= DVS_W'(n_q);
					rem_q <= '0;
				end
			end
			ST_THR_MUL: kprod_q <= sigma_multiple * sres_q;
			ST_THR_ADD: th_q <= tsum[T_W-1:8];
			ST_TAB_USE: begin
				dvd_q      <= DVD_W'(s_sel);
				dvs_q      <= DVS_W'(c_sel);
				rem_q      <= '0;
				evc_hold_q <= t_cnt;
			end
			ST_OUT: begin
				if (out_load) begin
					avg_q <= (|dvd_q[DVD_W-1:cntc_pkg::OUT_W]) ? '1 :
						dvd_q[cntc_pkg::OUT_W-1:0];
					evc_q <= evc_hold_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid      = ovalid_q;
	assign avg_threshold = avg_q;
	assign event_count   = evc_q;

	`CNTC_ASSERT_NEXT(a_out_after_load, out_load, m_tvalid)
	`CNTC_ASSERT_NEXT(a_idle_after_update, mem_we && st_q == ST_TAB_USE, st_q == ST_IDLE)
	`CNTC_ASSERT_NOW(a_clear_no_out, st_q == ST_CLEAR, !ovalid_q && !pop)

endmodule

FILE: hdl/channel_noise_threshold_calibrator.sv
// top level of the per-channel noise threshold calibrator
// samples: one transaction per cycle while the job queue has room and the tables are not being cleared
// waveform close: the back part works through the bit-serial multiplier, divider and root,
// taking one job at a time; short waveforms fill the queue
// read: once the back part takes the job, it passes the table read, divider and output register before m_tvalid rises
// after reset the tables are cleared one entry a cycle, all 2048 entries, input held off
module channel_noise_threshold_calibrator #(
	parameter int WAVE_SAMPLES          = cntc_pkg::WAVE_SAMPLES_DEF,
	parameter int NUM_FRONTENDS         = cntc_pkg::NUM_FRONTENDS_DEF,
	parameter int CHANNELS_PER_FRONTEND = cntc_pkg::CHANNELS_PER_FRONTEND_DEF,
	parameter int SAMPLE_BITS           = cntc_pkg::SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata, // frontend_id[7:0], channel_number[14:8], sample_value[26:15]
	input  logic s_tuser,        // cmd
	input  logic s_tlast,        // last_sample
	output logic m_tvalid,
	input  logic m_tready,
	output logic [31:0] m_tdata, // avg_threshold[15:0], event_count[31:16]
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int LEN_W = $clog2(WAVE_SAMPLES+1);
	localparam int DEPTH = NUM_FRONTENDS * CHANNELS_PER_FRONTEND;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int JOB_W = 1 + IDX_W + 3*SAMPLE_BITS + 3*LEN_W;

	// configuration registers
	logic [cntc_pkg::SIGMA_W-1:0] sigma_q;
	logic [cntc_pkg::DFLT_W-1:0] dflt_q;
	logic cfg_wr;

	// front to queue to back
	logic push, pop, full, empty, clearing;
	logic [JOB_W-1:0] job_in, job_out;
	logic [cntc_pkg::OUT_W-1:0] avg, evc;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// word-aligned decode, low address bits are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= cntc_pkg::SIGMA_RESET;
			dflt_q  <= cntc_pkg::DFLT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				cntc_pkg::REG_SIGMA:   sigma_q <= pwdata[cntc_pkg::SIGMA_W-1:0];
				cntc_pkg::REG_DEFAULT: dflt_q  <= pwdata[cntc_pkg::DFLT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			cntc_pkg::REG_SIGMA:   prdata = 32'(sigma_q);
			cntc_pkg::REG_DEFAULT: prdata = 32'(dflt_q);
			default:               prdata = '0;
		endcase
	end

	// front part: accumulates sums and emits a job per read or closed waveform of a valid channel
	cntc_front #(
		.WAVE_SAMPLES(WAVE_SAMPLES),
		.NUM_FRONTENDS(NUM_FRONTENDS),
		.CHANNELS_PER_FRONTEND(CHANNELS_PER_FRONTEND),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.cmd(s_tuser),
		.frontend_id(s_tdata[7:0]),
		.channel_number(s_tdata[14:8]),
		.sample_value(s_tdata[26:15]),
		.last_sample(s_tlast),
		.full(full),
		.clearing(clearing),
		.push(push),
		.job(job_in)
	);

	// short job queue decoupling the two parts
	cntc_fifo #(
		.W(JOB_W),
		.DEPTH(cntc_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(job_in),
		.pop(pop),
		.rdata(job_out),
		.full(full),
		.empty(empty)
	);

	// back part: threshold maths, channel tables and the output register
	cntc_back #(
		.WAVE_SAMPLES(WAVE_SAMPLES),
		.NUM_FRONTENDS(NUM_FRONTENDS),
		.CHANNELS_PER_FRONTEND(CHANNELS_PER_FRONTEND),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.sigma_multiple(sigma_q),
		.default_threshold(dflt_q),
		.empty(empty),
		.job(job_out),
		.pop(pop),
		.clearing(clearing),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.avg_threshold(avg),
		.event_count(evc)
	);

	assign m_tdata = {evc, avg};

endmodule
